/* rtl/core/iso8601_utc_to_epoch_parser_top_defines.svh */
// Assertion helpers used by the parser top level.
// Each macro expects clk and rst to be in scope.
`ifndef ISO8601_UTC_TO_EPOCH_PARSER_TOP_DEFINES_SVH
`define ISO8601_UTC_TO_EPOCH_PARSER_TOP_DEFINES_SVH

// Same-cycle implication.
`define ISO2EP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iso2ep: same-cycle check failed");

// Next-cycle implication.
`define ISO2EP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iso2ep: next-cycle check failed");

`endif

/* rtl/core/iso2ep_pkg.sv */
`timescale 1ns / 1ps

package iso2ep_pkg;

  localparam logic [13:0] YEAR_MIN      = 14'd1970;
  localparam logic [13:0] YEAR_MAX      = 14'd2100;
  localparam logic [13:0] YEAR_LEAP_REF = 14'd1969;
  localparam logic [6:0]  HOUR_MAX      = 7'd23;
  localparam logic [6:0]  MINSEC_MAX    = 7'd59;
  localparam logic [16:0] DAYS_PER_YEAR = 17'd365;
  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [16:0] SEC_PER_HOUR  = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN   = 17'd60;

  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } fields_t;

  // Handoff from the character parser to the epoch sequencer.
  typedef struct packed {
    logic    fin;
    logic    form_ok;
    fields_t fields;
  } lex_out_t;

endpackage

/* rtl/core/iso2ep_lexer.sv */
`timescale 1ns / 1ps

module iso2ep_lexer (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          char_code,
  input  logic                is_last,
  output iso2ep_pkg::lex_out_t lex
);
  import iso2ep_pkg::*;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [2:0] ZONE_LEN = 3'd6;

  typedef enum logic [2:0] {
    PH_FIXED,
    PH_AFTER_SEC,
    PH_FRAC_ONE,
    PH_FRAC_MORE,
    PH_ZONE_DONE,
    PH_PLUS
  } phase_t;

  function automatic logic [6:0] add_digit7(input logic [6:0] acc, input logic [3:0] dig);
    add_digit7 = {acc[3:0], 3'b000} + {acc[5:0], 1'b0} + {3'b000, dig};
  endfunction

  function automatic logic [13:0] add_digit14(input logic [13:0] acc, input logic [3:0] dig);
    add_digit14 = {acc[10:0], 3'b000} + {acc[12:0], 1'b0} + {10'd0, dig};
  endfunction

  // Expected character of "+00:00" at a given position.
  function automatic logic [7:0] zone_char(input logic [2:0] idx);
    case (idx)
      3'd0:    zone_char = CH_PLUS;
      3'd3:    zone_char = CH_COLON;
      default: zone_char = CH_ZERO;
    endcase
  endfunction

  logic [4:0] char_position, char_position_next;
  phase_t     parse_phase, parse_phase_next;
  logic [2:0] zone_index, zone_index_next;
  fields_t    flds, flds_next;
  logic       format_failed, format_failed_next;

  logic       is_dig;
  logic [3:0] dig;

  assign is_dig = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign dig    = char_code[3:0];

  always_comb begin
    char_position_next = char_position;
    parse_phase_next   = parse_phase;
    zone_index_next    = zone_index;
    flds_next          = flds;
    format_failed_next = format_failed;
    case (parse_phase)
      PH_FIXED: begin
        if (char_position == 5'd4 || char_position == 5'd7) begin
          if (char_code != CH_DASH) format_failed_next = 1'b1;
        end else if (char_position == 5'd10) begin
          if (char_code != CH_T) format_failed_next = 1'b1;
        end else if (char_position == 5'd13 || char_position == 5'd16) begin
          if (char_code != CH_COLON) format_failed_next = 1'b1;
        end else if (!is_dig) begin
          format_failed_next = 1'b1;
        end else if (char_position < 5'd4) begin
          flds_next.year = add_digit14(flds.year, dig);
        end else if (char_position < 5'd7) begin
          flds_next.month = add_digit7(flds.month, dig);
        end else if (char_position < 5'd10) begin
          flds_next.day = add_digit7(flds.day, dig);
        end else if (char_position < 5'd13) begin
          flds_next.hour = add_digit7(flds.hour, dig);
        end else if (char_position < 5'd16) begin
          flds_next.minute = add_digit7(flds.minute, dig);
        end else begin
          flds_next.second = add_digit7(flds.second, dig);
        end
        if (char_position >= 5'd18) parse_phase_next = PH_AFTER_SEC;
        else char_position_next = char_position + 5'd1;
      end
      PH_AFTER_SEC, PH_FRAC_MORE: begin
        if (parse_phase == PH_AFTER_SEC && char_code == CH_DOT) begin
          parse_phase_next = PH_FRAC_ONE;
        end else if (parse_phase == PH_FRAC_MORE && is_dig) begin
          parse_phase_next = PH_FRAC_MORE;
        end else if (char_code == CH_Z) begin
          parse_phase_next = PH_ZONE_DONE;
        end else if (char_code == CH_PLUS) begin
          parse_phase_next = PH_PLUS;
          zone_index_next  = 3'd1;
        end else begin
          format_failed_next = 1'b1;
        end
      end
      PH_FRAC_ONE: begin
        if (is_dig) parse_phase_next = PH_FRAC_MORE;
        else format_failed_next = 1'b1;
      end
      PH_PLUS: begin
        if (zone_index < ZONE_LEN && char_code == zone_char(zone_index)) begin
          zone_index_next = zone_index + 3'd1;
          if (zone_index_next == ZONE_LEN) parse_phase_next = PH_ZONE_DONE;
        end else begin
          format_failed_next = 1'b1;
        end
      end
      default: format_failed_next = 1'b1;
    endcase
  end

  assign lex.fin     = take && is_last;
  assign lex.form_ok = !format_failed_next && (parse_phase_next == PH_ZONE_DONE);
  assign lex.fields  = flds_next;

  always_ff @(posedge clk) begin
    if (rst || (take && is_last)) begin
      char_position <= '0;
      parse_phase   <= PH_FIXED;
      zone_index    <= '0;
      flds          <= '0;
      format_failed <= 1'b0;
    end else if (take) begin
      char_position <= char_position_next;
      parse_phase   <= parse_phase_next;
      zone_index    <= zone_index_next;
      flds          <= flds_next;
      format_failed <= format_failed_next;
    end
  end

endmodule

/* rtl/core/iso2ep_mac.sv */
`timescale 1ns / 1ps

// Registered multiply-add: acc <= a * b + c, kept to 32 bits.
module iso2ep_mac (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] a,
  input  logic [16:0] b,
  input  logic [31:0] c,
  output logic [31:0] acc
);

  logic [33:0] prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    if (en) acc <= prod[31:0] + c;
  end

endmodule

/* rtl/core/iso2ep_epoch.sv */
`timescale 1ns / 1ps

module iso2ep_epoch (
  input  logic                 clk,
  input  logic                 rst,
  input  iso2ep_pkg::lex_out_t lex,
  input  logic                 res_take,
  output logic                 busy,
  output logic                 res_ready,
  output logic                 res_ok,
  output logic [31:0]          res_secs
);
  import iso2ep_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DAYS,
    ST_SECS,
    ST_HOURS,
    ST_MINS,
    ST_HOLD
  } state_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd2:                    month_len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default:                 month_len = 5'd31;
    endcase
  endfunction

  // Days before the first of each month in a common year.
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    case (m)
      4'd2:    cum_days = 9'd31;
      4'd3:    cum_days = 9'd59;
      4'd4:    cum_days = 9'd90;
      4'd5:    cum_days = 9'd120;
      4'd6:    cum_days = 9'd151;
      4'd7:    cum_days = 9'd181;
      4'd8:    cum_days = 9'd212;
      4'd9:    cum_days = 9'd243;
      4'd10:   cum_days = 9'd273;
      4'd11:   cum_days = 9'd304;
      4'd12:   cum_days = 9'd334;
      default: cum_days = 9'd0;
    endcase
  endfunction

  state_t     state;
  fields_t    f;
  logic       form_ok;
  logic       ok;
  logic [7:0] ydiff;
  logic [8:0] dsum;

  logic        leap;
  logic [4:0]  lim;
  logic        range_ok;
  logic [13:0] yoff;
  logic [13:0] yrel;
  logic        leap_adj;

  logic        mac_en;
  logic [16:0] mac_a, mac_b;
  logic [31:0] mac_c, mac_r;

  // Within 1970..2100 only 2100 breaks the every-fourth-year rule.
  assign leap     = (f.year[1:0] == 2'b00) && (f.year != YEAR_MAX);
  assign lim      = month_len(f.month[3:0]) + {4'd0, (f.month == 7'd2) && leap};
  assign range_ok = (f.year >= YEAR_MIN) && (f.year <= YEAR_MAX) &&
                    (f.month >= 7'd1) && (f.month <= 7'd12) &&
                    (f.day >= 7'd1) && (f.day <= {2'b00, lim}) &&
                    (f.hour <= HOUR_MAX) && (f.minute <= MINSEC_MAX) &&
                    (f.second <= MINSEC_MAX);
  assign yoff     = f.year - YEAR_LEAP_REF;
  assign yrel     = f.year - YEAR_MIN;
  assign leap_adj = (f.month > 7'd2) && leap;

  always_comb begin
    mac_en = 1'b1;
    mac_a  = '0;
    mac_b  = '0;
    mac_c  = '0;
    case (state)
      ST_DAYS: begin
        mac_a = {9'd0, ydiff};
        mac_b = DAYS_PER_YEAR;
        mac_c = {23'd0, dsum};
      end
      ST_SECS: begin
        mac_a = mac_r[16:0];
        mac_b = SEC_PER_DAY;
        mac_c = {25'd0, f.second};
      end
      ST_HOURS: begin
        mac_a = {10'd0, f.hour};
        mac_b = SEC_PER_HOUR;
        mac_c = mac_r;
      end
      ST_MINS: begin
        mac_a = {10'd0, f.minute};
        mac_b = SEC_PER_MIN;
        mac_c = mac_r;
      end
      default: mac_en = 1'b0;
    endcase
  end

  iso2ep_mac u_mac (
    .clk (clk),
    .en  (mac_en),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .acc (mac_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (lex.fin) begin
            f       <= lex.fields;
            form_ok <= lex.form_ok;
            state   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          ok    <= form_ok && range_ok;
          ydiff <= yrel[7:0];
          dsum  <= {3'd0, yoff[7:2]} + cum_days(f.month[3:0]) + {8'd0, leap_adj} +
                   {2'b00, f.day} - 9'd1;
          state <= ST_DAYS;
        end
        ST_DAYS:  state <= ST_SECS;
        ST_SECS:  state <= ST_HOURS;
        ST_HOURS: state <= ST_MINS;
        ST_MINS:  state <= ST_HOLD;
        ST_HOLD: begin
          if (res_take) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (state != ST_IDLE);
  assign res_ready = (state == ST_HOLD);
  assign res_ok    = ok;
  assign res_secs  = ok ? mac_r : 32'd0;

endmodule

/* rtl/core/iso8601_utc_to_epoch_parser_top.sv */
`timescale 1ns / 1ps
// Channel   Dir  tdata                        tuser          tlast
// s_*       in   [7:0] char_code              -              is_last
// m_*       out  [31:0] unix_secs             [0] valid_res  -
//
// A character that is not the final one is taken while the epoch sequencer is idle.
// After the final character no word is taken until its result is handed on: one
// range check, then four passes through the shared 17x17 multiply-add
// (days, day seconds, hours, minutes), then the hand-off to the output word.
// rst is synchronous and active high; it clears the parser, holds s_tready low
// and drops m_tvalid.
// The output word holds under m_tready low; the parser keeps taking characters while
// it waits, then stalls from the next final character until that result is handed on.
`include "iso8601_utc_to_epoch_parser_top_defines.svh"

module iso8601_utc_to_epoch_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] unix_secs
  output logic        m_tuser    // [0] valid_res
);
  import iso2ep_pkg::*;

  lex_out_t    lex;
  logic        take;
  logic        busy;
  logic        res_ready;
  logic        res_take;
  logic        res_ok;
  logic [31:0] res_secs;

  // Take characters only out of reset and while the epoch sequencer is free.
  assign s_tready = !rst && !busy;
  assign take     = s_tvalid && s_tready;

  iso2ep_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (s_tdata),
    .is_last   (s_tlast),
    .lex       (lex)
  );

  iso2ep_epoch u_epoch (
    .clk       (clk),
    .rst       (rst),
    .lex       (lex),
    .res_take  (res_take),
    .busy      (busy),
    .res_ready (res_ready),
    .res_ok    (res_ok),
    .res_secs  (res_secs)
  );

  // Move a finished result into the output word when that word is empty
  // or leaving in this cycle.
  assign res_take = res_ready && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= res_secs;
      m_tuser <= res_ok;
    end
  end

  // A rejected text always reports zero seconds.
  `ISO2EP_ASSERT_NOW(a_bad_text_zero, m_tvalid && !m_tuser, m_tdata == 32'd0)
  // A good text never lies past the end of 2100.
  `ISO2EP_ASSERT_NOW(a_secs_in_range, m_tvalid && m_tuser, m_tdata <= 32'd4133980799)
  // Hold off input while the final character is being worked out.
  `ISO2EP_ASSERT_NEXT(a_stall_after_last, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule

/* dv/tb_iso8601_utc_to_epoch_parser_top.sv */
`timescale 1ns / 1ps

module tb_iso8601_utc_to_epoch_parser_top;

  // Where the parser stands within one timestamp text.
  typedef enum logic [2:0] {
    ST_FIXED,       // inside YYYY-MM-DDTHH:MM:SS
    ST_AFTER_SEC,   // seconds done, expect '.', 'Z' or '+'
    ST_FRAC_FIRST,  // '.' seen, at least one digit needed
    ST_FRAC_REST,   // further fraction digits or the zone
    ST_ZONE_DONE,   // zone complete, nothing more allowed
    ST_OFFSET       // inside "+00:00"
  } parse_state_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] secs;
  } stamp_t;

  // Shadow of the parser: follows every accepted character word and keeps
  // the stamps still owed by the block, oldest first.
  class epoch_scoreboard;
    parse_state_t state = ST_FIXED;
    bit [4:0]  pos;
    bit [2:0]  zone_idx;
    bit [13:0] year_acc;
    bit [6:0]  month_acc, day_acc, hour_acc, minute_acc, second_acc;
    bit        broken;
    stamp_t    owed_q[$];
    int        errors;
    string     offset_text = "+00:00";

    function void restart();
      state = ST_FIXED;
      pos = '0;
      zone_idx = '0;
      year_acc = '0;
      month_acc = '0;
      day_acc = '0;
      hour_acc = '0;
      minute_acc = '0;
      second_acc = '0;
      broken = 1'b0;
    endfunction

    function bit is_digit(bit [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void zone_begin(bit [7:0] c);
      if (c == "Z") begin
        state = ST_ZONE_DONE;
      end else if (c == "+") begin
        state = ST_OFFSET;
        zone_idx = 3'd1;
      end else begin
        broken = 1'b1;
      end
    endfunction

    function void fixed_part(bit [7:0] c);
      bit [7:0] d;
      d = c - "0";
      case (pos)
        5'd4, 5'd7:   if (c != "-") broken = 1'b1;
        5'd10:        if (c != "T") broken = 1'b1;
        5'd13, 5'd16: if (c != ":") broken = 1'b1;
        default: begin
          if (!is_digit(c)) broken = 1'b1;
          else if (pos < 4)  year_acc   = 14'(year_acc * 10 + d);
          else if (pos < 7)  month_acc  = 7'(month_acc * 10 + d);
          else if (pos < 10) day_acc    = 7'(day_acc * 10 + d);
          else if (pos < 13) hour_acc   = 7'(hour_acc * 10 + d);
          else if (pos < 16) minute_acc = 7'(minute_acc * 10 + d);
          else               second_acc = 7'(second_acc * 10 + d);
        end
      endcase
      if (pos >= 18) state = ST_AFTER_SEC;
      else pos = pos + 5'd1;
    endfunction

    function bit fields_ok();
      int unsigned lim;
      bit leap;
      if (year_acc < 1970 || year_acc > 2100) return 1'b0;
      if (month_acc < 1 || month_acc > 12) return 1'b0;
      leap = (year_acc % 4 == 0) && ((year_acc % 100 != 0) || (year_acc % 400 == 0));
      case (month_acc)
        7'd4, 7'd6, 7'd9, 7'd11: lim = 30;
        7'd2:                     lim = leap ? 29 : 28;
        default:                  lim = 31;
      endcase
      if (day_acc < 1 || day_acc > lim) return 1'b0;
      return hour_acc <= 23 && minute_acc <= 59 && second_acc <= 59;
    endfunction

    // Days from the civil calendar, years taken from March.
    function bit [31:0] epoch_secs();
      longint unsigned y, era, yoe, mp, doy, doe, days;
      y    = year_acc - ((month_acc <= 2) ? 1 : 0);
      era  = y / 400;
      yoe  = y - era * 400;
      mp   = (month_acc > 2) ? month_acc - 3 : month_acc + 9;
      doy  = (153 * mp + 2) / 5 + day_acc - 1;
      doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 146097 + doe - 719468;
      return 32'(days * 86400 + hour_acc * 3600 + minute_acc * 60 + second_acc);
    endfunction

    function void note_char(bit [7:0] c, bit last);
      stamp_t s;
      case (state)
        ST_FIXED:      fixed_part(c);
        ST_AFTER_SEC:  if (c == ".") state = ST_FRAC_FIRST; else zone_begin(c);
        ST_FRAC_FIRST: if (is_digit(c)) state = ST_FRAC_REST; else broken = 1'b1;
        ST_FRAC_REST:  if (!is_digit(c)) zone_begin(c);
        ST_OFFSET: begin
          if (zone_idx < 6 && c == offset_text[zone_idx]) begin
            zone_idx = zone_idx + 3'd1;
            if (zone_idx == 6) state = ST_ZONE_DONE;
          end else begin
            broken = 1'b1;
          end
        end
        default:       broken = 1'b1;
      endcase
      if (last) begin
        s.ok = !broken && state == ST_ZONE_DONE && fields_ok();
        s.secs = s.ok ? epoch_secs() : 32'd0;
        owed_q.push_back(s);
        restart();
      end
    endfunction

    function void check_result(bit ok, bit [31:0] secs);
      stamp_t s;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected stamp: expected none, got valid=%0b secs=%0d",
                 $time, ok, secs);
        errors++;
        return;
      end
      s = owed_q.pop_front();
      if (ok !== s.ok) begin
        $display("%0t: valid_res mismatch: expected %0b, got %0b", $time, s.ok, ok);
        errors++;
      end
      if (secs !== s.secs) begin
        $display("%0t: unix_secs mismatch: expected %0d, got %0d",
                 $time, s.secs, secs);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] char_code
  logic        s_tlast = 1'b0;    // is_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [31:0] unix_secs
  logic        m_tuser;           // [0] valid_res

  epoch_scoreboard sb;
  bit [7:0] text_q[$];
  int       chars_sent;
  int       hold_left;
  bit       hold_used;
  bit       quiet;

  iso8601_utc_to_epoch_parser_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Stretch with no idling on either side.
  assign quiet = chars_sent >= 500 && chars_sent < 800;

  // Check every stamp word taken at the output.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  // Receiver: random back-pressure, plus one long hold-off counted here while
  // the sender keeps offering, so the block fills up and stalls its input.
  initial begin
    forever begin
      @(negedge clk);
      if (!hold_used && chars_sent >= 1100) begin
        hold_left = 400;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (quiet) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 23);
      end
    end
  end

  // Offer one character word; idle first at random, then hold until taken.
  task automatic send_char(bit [7:0] c, bit last);
    while (!quiet && $urandom_range(0, 99) < 23) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_char(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Drop valid and hold off until every owed stamp has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void put_num(int unsigned v, int n);
    int unsigned div;
    div = 1;
    for (int i = 1; i < n; i++) div = div * 10;
    for (int i = 0; i < n; i++) begin
      text_q.push_back(8'((v / div) % 10) + "0");
      div = div / 10;
    end
  endfunction

  // Field value: mostly in range, sometimes anywhere two digits reach.
  function automatic int unsigned pick_field(int unsigned lo, int unsigned hi);
    if ($urandom_range(0, 99) < 85) return $urandom_range(lo, hi);
    return $urandom_range(0, 99);
  endfunction

  // Build one random text into text_q: mostly well formed with random content,
  // some pure noise, some well formed and then broken.
  function automatic void build_text();
    int unsigned kind, len, k;
    string zone_chars;
    zone_chars = "0123456789-:T.Z+";
    if ($urandom_range(0, 99) < 8) begin
      len = $urandom_range(1, 30);
      repeat (len) begin
        if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(1, 255)));
        else text_q.push_back(zone_chars[$urandom_range(0, zone_chars.len() - 1)]);
      end
      return;
    end
    if ($urandom_range(0, 99) < 85) put_num($urandom_range(1970, 2100), 4);
    else put_num($urandom_range(0, 9999), 4);
    put_str("-");
    put_num(pick_field(1, 12), 2);
    put_str("-");
    put_num(pick_field(1, 31), 2);
    put_str("T");
    put_num(pick_field(0, 23), 2);
    put_str(":");
    put_num(pick_field(0, 59), 2);
    put_str(":");
    put_num(pick_field(0, 59), 2);
    if ($urandom_range(0, 99) < 40) begin
      put_str(".");
      repeat ($urandom_range(1, 5)) put_num($urandom_range(0, 9), 1);
    end
    if ($urandom_range(0, 99) < 60) put_str("Z");
    else put_str("+00:00");
    if ($urandom_range(0, 99) < 25) begin
      kind = $urandom_range(0, 2);
      case (kind)
        0: begin
          k = $urandom_range(0, text_q.size() - 1);
          text_q[k] = 8'($urandom_range(1, 255));
        end
        1: begin
          k = $urandom_range(1, text_q.size() - 1);
          while (text_q.size() > k) void'(text_q.pop_back());
        end
        default: begin
          repeat ($urandom_range(1, 3))
            text_q.push_back(zone_chars[$urandom_range(0, zone_chars.len() - 1)]);
        end
      endcase
    end
  endfunction

  initial begin
    string directed[$];
    int    random_chars;
    int    random_texts;
    sb = new;
    sb.restart();

    // Extremes of the year range and of each field, leap days, every zone
    // form, fraction forms, text ending early and characters after the zone.
    directed = '{
      "1970-01-01T00:00:00Z",
      "2100-12-31T23:59:59Z",
      "2000-02-29T12:34:56.789+00:00",
      "2024-02-29T23:59:59.5Z",
      "2100-02-29T00:00:00Z",
      "1969-12-31T23:59:59Z",
      "2101-01-01T00:00:00Z",
      "2023-00-10T00:00:00Z",
      "2023-13-10T00:00:00Z",
      "2023-04-31T00:00:00Z",
      "2023-04-00T00:00:00Z",
      "2023-06-15T24:00:00Z",
      "2023-06-15T10:60:00Z",
      "2023-06-15T10:00:60Z",
      "2023-06-15T10:00",
      "2023-06-15T10:00:00Z5",
      "2023-06-15T10:00:00+00:00Z",
      "2023-06-15T10:00:00+01:00",
      "2023-06-15T10:00:00.Z",
      "2023-06-15 10:00:00Z",
      "2023/06/15T10:00:00Z",
      "2O23-06-15T10:00:00Z",
      "Z",
      "2023-06-15T10:00:00"
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      put_str(directed[i]);
      send_text();
    end
    // Sender pause: let everything owed come back before going random.
    drain();

    random_chars = 0;
    random_texts = 0;
    while (random_chars < 1000 || random_texts < 48) begin
      build_text();
      random_chars += text_q.size();
      random_texts++;
      send_text();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("iso8601_utc_to_epoch_parser_top regression: pass");
    end else begin
      $display("iso8601_utc_to_epoch_parser_top regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("%0t: timeout with %0d stamps owed", $time, sb.pending());
    $display("iso8601_utc_to_epoch_parser_top regression: fail");
    $finish;
  end

endmodule
